// ===== hw/rtl/ubxfp_pkg.sv =====
`timescale 1ns / 1ps

package ubxfp_pkg;

    localparam logic [7:0] SYNC_FIRST  = 8'hB5;
    localparam logic [7:0] SYNC_SECOND = 8'h62;

    localparam logic [7:0]  RST_WANTED_CLASS = 8'h01;
    localparam logic [7:0]  RST_WANTED_ID    = 8'h07;
    localparam logic [15:0] RST_MAX_PAYLOAD  = 16'd92;

    // configuration register indexes
    typedef enum logic [1:0] {
        REG_WANTED_CLASS = 2'd0,
        REG_WANTED_ID    = 2'd1,
        REG_MAX_PAYLOAD  = 2'd2
    } reg_index_t;

    // deframer phases
    typedef enum logic [3:0] {
        PH_SYNC1       = 4'd0,
        PH_SYNC2       = 4'd1,
        PH_CLASS       = 4'd2,
        PH_ID          = 4'd3,
        PH_LEN_LO      = 4'd4,
        PH_LEN_HI      = 4'd5,
        PH_PAYLOAD     = 4'd6,
        PH_CK_A        = 4'd7,
        PH_CK_B        = 4'd8,
        PH_SKIP_ID     = 4'd9,
        PH_SKIP_LEN_LO = 4'd10,
        PH_SKIP_LEN_HI = 4'd11
    } phase_t;

    // result kinds
    typedef enum logic [1:0] {
        KIND_PAYLOAD  = 2'd0,
        KIND_GOOD     = 2'd1,
        KIND_CK_FAIL  = 2'd2,
        KIND_TOO_LONG = 2'd3
    } kind_t;

    typedef struct packed {
        logic [15:0] frame_length;
        logic [15:0] offset;
        logic [7:0]  data_byte;
    } result_data_t;

endpackage

// ===== hw/rtl/ubx_frame_parser.sv =====
`timescale 1ns / 1ps

// channel   dir  fields (low bit first)                     accepted when
// --------  ---  -----------------------------------------  -----------------------
// s_axis    in   tdata: rx_byte[7:0]                        s_tvalid && s_tready
// m_axis    out  tdata: data_byte, offset, frame_length;    m_tvalid && m_tready
//                tuser: kind[1:0]
// cfg       in   cfg_index selects register, cfg_wdata      cfg_wr_en
//
// one byte per cycle sustained while the receiver takes results; a request waits in the input register,
// then one pass of phase logic and the fletcher adders loads the result register;
// a result shows on m_tdata once its byte has passed the input register and then the result register
// rst_n (async, active low) returns to sync hunting and restores register defaults
// the input register stalls only while it holds a byte and the result register
// holds a result that the receiver has not taken
module ubx_frame_parser
(
    input  logic        clk,
    input  logic        rst_n,
    // configuration
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_wdata,
    // received bytes
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // rx_byte[7:0]
    // results
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // data_byte[7:0], offset[23:8], frame_length[39:24]
    output logic [1:0]  m_tuser    // kind[1:0]
);
    import ubxfp_pkg::*;

    // configuration registers
    logic [7:0]  wanted_class_reg;
    logic [7:0]  wanted_id_reg;
    logic [15:0] max_payload_reg;

    // input register
    logic        in_valid_reg;
    logic [7:0]  in_byte_reg;

    // deframer state
    phase_t      phase_reg, phase_next;
    logic [15:0] byte_count_reg, byte_count_next;
    logic [15:0] length_word_reg, length_word_next;
    logic [7:0]  sum_a_reg, sum_a_next;
    logic [7:0]  sum_b_reg, sum_b_next;
    logic [7:0]  got_ck_a_reg, got_ck_a_next;

    // result register
    logic         out_valid_reg;
    kind_t        out_kind_reg;
    result_data_t out_data_reg;

    // per-byte result
    logic         emit;
    kind_t        emit_kind;
    result_data_t emit_data;

    logic        advance;
    logic [7:0]  b;
    logic [15:0] len_full;
    logic [15:0] count_inc;
    logic [7:0]  acc_a;
    logic [7:0]  acc_b;

    assign b         = in_byte_reg;
    assign len_full  = {b, length_word_reg[7:0]};
    assign count_inc = byte_count_reg + 16'd1;
    // running fletcher step on the held byte
    assign acc_a     = sum_a_reg + b;
    assign acc_b     = sum_b_reg + acc_a;

    // the held byte moves on when the result register can take what it yields
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_kind_reg;

    // configuration writes, index beyond the list ignored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wanted_class_reg <= RST_WANTED_CLASS;
            wanted_id_reg    <= RST_WANTED_ID;
            max_payload_reg  <= RST_MAX_PAYLOAD;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_WANTED_CLASS: wanted_class_reg <= cfg_wdata[7:0];
                REG_WANTED_ID:    wanted_id_reg    <= cfg_wdata[7:0];
                REG_MAX_PAYLOAD:  max_payload_reg  <= cfg_wdata;
                default:          ;
            endcase
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_byte_reg <= s_tdata;
        end
    end

    // next phase
    always_comb
    begin
        phase_next = phase_reg;
        unique case (phase_reg)
            PH_SYNC1:
            begin
                if (b == SYNC_FIRST)
                    phase_next = PH_SYNC2;
            end
            PH_SYNC2:
            begin
                if (b == SYNC_SECOND)
                    phase_next = PH_CLASS;
                else if (b != SYNC_FIRST)
                    phase_next = PH_SYNC1;
            end
            PH_CLASS:       phase_next = (b == wanted_class_reg) ? PH_ID : PH_SKIP_ID;
            PH_ID:          phase_next = (b == wanted_id_reg) ? PH_LEN_LO : PH_SKIP_LEN_LO;
            PH_LEN_LO:      phase_next = PH_LEN_HI;
            PH_LEN_HI:
            begin
                if (len_full > max_payload_reg)
                    phase_next = PH_SYNC1;
                else if (len_full == 16'd0)
                    phase_next = PH_CK_A;
                else
                    phase_next = PH_PAYLOAD;
            end
            PH_PAYLOAD:
            begin
                if (count_inc == length_word_reg)
                    phase_next = PH_CK_A;
            end
            PH_CK_A:        phase_next = PH_CK_B;
            PH_CK_B:        phase_next = PH_SYNC1;
            PH_SKIP_ID:     phase_next = PH_SKIP_LEN_LO;
            PH_SKIP_LEN_LO: phase_next = PH_SKIP_LEN_HI;
            PH_SKIP_LEN_HI: phase_next = PH_SYNC1;
            default:        phase_next = PH_SYNC1;
        endcase
    end

    // datapath and result
    always_comb
    begin
        byte_count_next  = byte_count_reg;
        length_word_next = length_word_reg;
        sum_a_next       = sum_a_reg;
        sum_b_next       = sum_b_reg;
        got_ck_a_next    = got_ck_a_reg;
        emit             = 1'b0;
        emit_kind        = KIND_PAYLOAD;
        emit_data        = '0;
        unique case (phase_reg)
            PH_CLASS:
            begin
                // sums restart at the class byte
                sum_a_next = b;
                sum_b_next = b;
            end
            PH_ID:
            begin
                sum_a_next = acc_a;
                sum_b_next = acc_b;
            end
            PH_LEN_LO:
            begin
                sum_a_next       = acc_a;
                sum_b_next       = acc_b;
                length_word_next = {8'h00, b};
            end
            PH_LEN_HI:
            begin
                sum_a_next       = acc_a;
                sum_b_next       = acc_b;
                length_word_next = len_full;
                byte_count_next  = 16'd0;
                if (len_full > max_payload_reg)
                begin
                    emit                   = 1'b1;
                    emit_kind              = KIND_TOO_LONG;
                    emit_data.frame_length = len_full;
                end
            end
            PH_PAYLOAD:
            begin
                sum_a_next          = acc_a;
                sum_b_next          = acc_b;
                byte_count_next     = count_inc;
                emit                = 1'b1;
                emit_kind           = KIND_PAYLOAD;
                emit_data.data_byte = b;
                emit_data.offset    = byte_count_reg;
            end
            PH_CK_A:
            begin
                got_ck_a_next = b;
            end
            PH_CK_B:
            begin
                emit                   = 1'b1;
                emit_kind              = (got_ck_a_reg == sum_a_reg && b == sum_b_reg)
                                         ? KIND_GOOD : KIND_CK_FAIL;
                emit_data.frame_length = length_word_reg;
            end
            PH_SYNC1, PH_SYNC2, PH_SKIP_ID, PH_SKIP_LEN_LO, PH_SKIP_LEN_HI:
            begin
            end
            default:
            begin
                // unused phase code
                byte_count_next = 16'd0;
            end
        endcase
    end

    // deframer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_SYNC1;
            byte_count_reg  <= '0;
            length_word_reg <= '0;
            sum_a_reg       <= '0;
            sum_b_reg       <= '0;
            got_ck_a_reg    <= '0;
        end
        else if (advance)
        begin
            phase_reg       <= phase_next;
            byte_count_reg  <= byte_count_next;
            length_word_reg <= length_word_next;
            sum_a_reg       <= sum_a_next;
            sum_b_reg       <= sum_b_next;
            got_ck_a_reg    <= got_ck_a_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance && emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && emit)
        begin
            out_kind_reg <= emit_kind;
            out_data_reg <= emit_data;
        end
    end

    // a payload byte always yields a result in the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (advance && phase_reg == PH_PAYLOAD) |=> m_tvalid)
        else $error("payload byte produced no result");

    // inside the payload the count stays below the frame length
    assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_PAYLOAD) |-> (byte_count_reg < length_word_reg))
        else $error("payload count ran past frame length");

    // closing results carry no byte or offset
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser != KIND_PAYLOAD) |-> (m_tdata[23:0] == 24'd0))
        else $error("closing result carries payload fields");

    // back-pressure only while a byte is held
    assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (in_valid_reg && out_valid_reg))
        else $error("input stalled with nothing held");

endmodule
